/* sv/cpk_pkg.sv */
// Shared types, codes and code conversion tables of the console printer/keyboard adapter.
package cpk_pkg;

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_LOAD  = 3'd1,
        MODE_TEST  = 3'd2,
        MODE_SENSE = 3'd3,
        MODE_APL   = 3'd4,
        MODE_TICK  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RESET   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_REQUEST = 2'd0,
        REG_RETURN  = 2'd1,
        REG_CANCEL  = 2'd2,
        REG_END     = 2'd3
    } reg_index_t;

    // Flag word bit positions
    localparam int unsigned FB_INTRST   = 0;
    localparam int unsigned FB_KEYINT   = 1;
    localparam int unsigned FB_REQINT   = 2;
    localparam int unsigned FB_PROLIGHT = 4;
    localparam int unsigned FB_REQLIGHT = 5;
    localparam int unsigned FB_INTKEY   = 8;
    localparam int unsigned FB_INTEND   = 9;
    localparam int unsigned FB_INTREQ   = 10;
    localparam int unsigned FB_PRTREQ   = 11;
    localparam int unsigned FB_PRTBUSY  = 12;
    localparam int unsigned FB_PRTINT   = 13;

    localparam int unsigned FLAG_W      = 14;
    localparam logic [FLAG_W-1:0] FLAG_KEEP_MASK = 14'h3FC0;
    localparam logic [15:0] START_KBD_MASK = 16'h003F;

    // Start data bits for the printer
    localparam int unsigned PB_PRINT    = 7;
    localparam int unsigned PB_NEWLINE  = 6;
    localparam int unsigned PB_INTEN    = 2;
    localparam int unsigned PB_INTRST   = 0;

    // Device codes of the special keys
    localparam logic [7:0] KB_RETURN = 8'h12;
    localparam logic [7:0] KB_END    = 8'h0D;
    localparam logic [7:0] KB_CANCEL = 8'h03;

    localparam logic [2:0] SENSE_PAIR_LO = 3'd1;
    localparam logic [2:0] SENSE_PAIR_HI = 3'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic        unit_select;
        logic [2:0]  modifier;
        logic [15:0] io_data;
        logic [3:0]  cpu_level;
        logic        key_valid;
        logic [7:0]  key_char;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] sense_data;
        logic        print_valid;
        logic [7:0]  print_char;
        logic        print_newline;
        logic        irq_raise;
        logic        key_consumed;
        logic        request_light;
        logic        proceed_light;
    } out_item_t;

    typedef struct packed {
        logic [6:0] request_code;
        logic [6:0] return_code;
        logic [6:0] cancel_code;
        logic [6:0] end_code;
    } key_cfg_t;

    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        logic [7:0]        keyboard_byte;
        logic [7:0]        printer_byte;
    } dev_state_t;

    localparam logic [6:0] RST_REQUEST_CODE = 7'd1;
    localparam logic [6:0] RST_RETURN_CODE  = 7'd18;
    localparam logic [6:0] RST_CANCEL_CODE  = 7'd27;
    localparam logic [6:0] RST_END_CODE     = 7'd13;

    localparam logic [7:0] DEV_TO_HOST [0:255] = '{
        8'h00,8'h01,8'h02,8'h03,8'hA6,8'h09,8'hA7,8'h7F,8'hA9,8'hB0,8'hB1,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
        8'h10,8'h11,8'h12,8'h13,8'hB2,8'hB4,8'h08,8'hB7,8'h18,8'h19,8'h1A,8'hB8,8'hBA,8'h1D,8'hBB,8'h1F,
        8'hBD,8'hC0,8'h1C,8'hC1,8'hC2,8'h0A,8'h17,8'h1B,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'h05,8'h06,8'h07,
        8'hC8,8'hC9,8'h16,8'hCB,8'hCC,8'h1E,8'hCD,8'h04,8'hCE,8'hD0,8'hD1,8'hD2,8'h14,8'h15,8'hD3,8'hFC,
        8'h20,8'hD4,8'h83,8'h84,8'h85,8'hA0,8'hD5,8'h86,8'h87,8'hA4,8'h7E,8'h2E,8'h3C,8'h28,8'h2B,8'h7C,
        8'h26,8'h82,8'h88,8'h89,8'h8A,8'hA1,8'h8C,8'h8B,8'h8D,8'hD8,8'h21,8'h24,8'h2A,8'h29,8'h3B,8'h5E,
        8'h2D,8'h2F,8'hD9,8'h8E,8'hDB,8'hDC,8'hDD,8'h8F,8'h80,8'hA5,8'h7C,8'h2C,8'h25,8'h5F,8'h3E,8'h3F,
        8'hDE,8'h90,8'hDF,8'hE0,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'h60,8'h3A,8'h23,8'h40,8'h27,8'h3D,8'h22,
        8'hE7,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'hAE,8'hAF,8'hE8,8'hE9,8'hEA,8'hEC,
        8'hF0,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,8'h70,8'h71,8'h72,8'hF1,8'hF2,8'h91,8'hF3,8'h92,8'hF4,
        8'hF5,8'h7E,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'hAD,8'hA8,8'hF6,8'h5B,8'hF7,8'hF8,
        8'h9B,8'h9C,8'h9D,8'h9E,8'h9F,8'hB5,8'hB6,8'hAC,8'hAB,8'hB9,8'hAA,8'hB3,8'hBC,8'h5D,8'hBE,8'hBF,
        8'h7B,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'hCA,8'h93,8'h94,8'h95,8'hA2,8'hCF,
        8'h7D,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'hDA,8'h96,8'h81,8'h97,8'hA3,8'h98,
        8'h5C,8'hE1,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'hFD,8'hEB,8'h99,8'hED,8'hEE,8'hEF,
        8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'hFE,8'hFB,8'h9A,8'hF9,8'hFA,8'hFF
    };

    localparam logic [7:0] HOST_TO_DEV [0:127] = '{
        8'h00,8'h01,8'h02,8'h03,8'h37,8'h2D,8'h2E,8'h2F,8'h16,8'h05,8'h25,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
        8'h10,8'h11,8'h12,8'h13,8'h3C,8'h3D,8'h32,8'h26,8'h18,8'h19,8'h1A,8'h27,8'h22,8'h1D,8'h35,8'h1F,
        8'h40,8'h5A,8'h7F,8'h7B,8'h5B,8'h6C,8'h50,8'h7D,8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
        8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
        8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
        8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hAD,8'hE0,8'hBD,8'h5F,8'h6D,
        8'h79,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
        8'h97,8'h98,8'h99,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hC0,8'h4F,8'hD0,8'h4A,8'h07
    };

endpackage

/* sv/cpk_apb_regs.sv */
// APB register file holding the four host key codes.
module cpk_apb_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cpk_pkg::key_cfg_t cfg
);

    cpk_pkg::key_cfg_t cfg_reg;
    logic              wr_en;
    logic [1:0]        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.request_code <= cpk_pkg::RST_REQUEST_CODE;
            cfg_reg.return_code  <= cpk_pkg::RST_RETURN_CODE;
            cfg_reg.cancel_code  <= cpk_pkg::RST_CANCEL_CODE;
            cfg_reg.end_code     <= cpk_pkg::RST_END_CODE;
        end else if (wr_en) begin
            case (reg_sel)
                cpk_pkg::REG_REQUEST: cfg_reg.request_code <= pwdata[6:0];
                cpk_pkg::REG_RETURN:  cfg_reg.return_code  <= pwdata[6:0];
                cpk_pkg::REG_CANCEL:  cfg_reg.cancel_code  <= pwdata[6:0];
                cpk_pkg::REG_END:     cfg_reg.end_code     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            cpk_pkg::REG_REQUEST: prdata = {25'd0, cfg_reg.request_code};
            cpk_pkg::REG_RETURN:  prdata = {25'd0, cfg_reg.return_code};
            cpk_pkg::REG_CANCEL:  prdata = {25'd0, cfg_reg.cancel_code};
            cpk_pkg::REG_END:     prdata = {25'd0, cfg_reg.end_code};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

/* sv/cpk_step.sv */
// Command and tick decode: next device state and the result item for one item.
module cpk_step (
    input  cpk_pkg::in_item_t   item,
    input  cpk_pkg::dev_state_t cur,
    input  cpk_pkg::key_cfg_t   cfg,
    output cpk_pkg::dev_state_t nxt,
    output cpk_pkg::out_item_t  res
);

    logic [6:0]  ac_raw;
    logic [6:0]  ac;
    logic        keyen;
    logic [15:0] sense_val;
    logic [15:0] data;

    assign data   = item.io_data;
    assign ac_raw = item.key_char[6:0];
    assign keyen  = cur.flags[cpk_pkg::FB_KEYINT];
    assign ac     = (ac_raw inside {[7'h61:7'h7A]}) ? ac_raw - 7'h20 : ac_raw;

    // Sense byte pairs
    always_comb begin
        sense_val = 16'd0;
        if (!item.unit_select) begin
            if (item.modifier == cpk_pkg::SENSE_PAIR_LO) begin
                sense_val[15:8] = cur.keyboard_byte;
                sense_val[2] = (cur.keyboard_byte == cpk_pkg::KB_RETURN);
                sense_val[3] = cur.flags[cpk_pkg::FB_INTKEY];
                sense_val[4] = (cur.keyboard_byte == cpk_pkg::KB_END);
                sense_val[5] = (cur.keyboard_byte == cpk_pkg::KB_CANCEL);
                sense_val[6] = cur.flags[cpk_pkg::FB_INTEND];
                sense_val[7] = cur.flags[cpk_pkg::FB_INTREQ];
            end else begin
                sense_val[6] = cur.flags[cpk_pkg::FB_KEYINT];
                sense_val[7] = cur.flags[cpk_pkg::FB_REQINT];
            end
        end else if (item.modifier == cpk_pkg::SENSE_PAIR_LO) begin
            sense_val[4] = cur.flags[cpk_pkg::FB_PRTBUSY];
            sense_val[7] = cur.flags[cpk_pkg::FB_PRTREQ];
        end
    end

    always_comb begin
        nxt = cur;
        res = '0;
        res.status = cpk_pkg::ST_OK;
        case (item.mode)
            cpk_pkg::MODE_START: begin
                if (item.modifier != 3'd0) begin
                    res.status = cpk_pkg::ST_INVALID;
                end else if (!item.unit_select) begin
                    nxt.flags = (cur.flags & cpk_pkg::FLAG_KEEP_MASK)
                              | cpk_pkg::FLAG_W'(data & cpk_pkg::START_KBD_MASK);
                    if (data[cpk_pkg::FB_INTRST]) begin
                        nxt.flags[cpk_pkg::FB_INTREQ] = 1'b0;
                        nxt.flags[cpk_pkg::FB_INTKEY] = 1'b0;
                        nxt.flags[cpk_pkg::FB_INTEND] = 1'b0;
                        res.status = cpk_pkg::ST_RESET;
                    end
                end else begin
                    if (data[cpk_pkg::PB_PRINT]) begin
                        res.print_valid = 1'b1;
                        res.print_char  = cpk_pkg::DEV_TO_HOST[cur.printer_byte];
                        nxt.flags[cpk_pkg::FB_PRTBUSY] = 1'b1;
                    end
                    if (data[cpk_pkg::PB_NEWLINE]) begin
                        res.print_newline = 1'b1;
                        nxt.flags[cpk_pkg::FB_PRTBUSY] = 1'b1;
                    end
                    nxt.flags[cpk_pkg::FB_PRTINT] = data[cpk_pkg::PB_INTEN];
                    if (data[cpk_pkg::PB_INTRST] && !item.cpu_level[3]) begin
                        if (!data[cpk_pkg::PB_PRINT]) begin
                            nxt.flags[cpk_pkg::FB_PRTREQ] = 1'b0;
                        end
                        res.status = cpk_pkg::ST_RESET;
                    end
                end
            end
            cpk_pkg::MODE_LOAD: begin
                if (item.modifier != 3'd0 || !item.unit_select) begin
                    res.status = cpk_pkg::ST_INVALID;
                end else begin
                    nxt.printer_byte = data[15:8];
                end
            end
            cpk_pkg::MODE_TEST, cpk_pkg::MODE_APL: begin
                res.status = cpk_pkg::ST_INVALID;
            end
            cpk_pkg::MODE_SENSE: begin
                if (item.modifier != cpk_pkg::SENSE_PAIR_LO
                        && item.modifier != cpk_pkg::SENSE_PAIR_HI) begin
                    res.status = cpk_pkg::ST_INVALID;
                end else begin
                    res.sense_data = sense_val;
                end
            end
            cpk_pkg::MODE_TICK: begin
                if (cur.flags[cpk_pkg::FB_PRTBUSY] && cur.flags[cpk_pkg::FB_PRTINT]) begin
                    // Printer completes first; a key waits for the next tick
                    nxt.flags[cpk_pkg::FB_PRTBUSY] = 1'b0;
                    nxt.flags[cpk_pkg::FB_PRTREQ]  = 1'b1;
                    res.irq_raise = 1'b1;
                end else if (item.key_valid) begin
                    res.key_consumed = 1'b1;
                    if (ac_raw == cfg.request_code) begin
                        if (cur.flags[cpk_pkg::FB_REQINT]) begin
                            nxt.flags[cpk_pkg::FB_INTREQ] = 1'b1;
                            res.irq_raise = 1'b1;
                        end
                    end else begin
                        nxt.keyboard_byte = cpk_pkg::HOST_TO_DEV[ac];
                        if (ac == cfg.end_code) begin
                            if (keyen) begin
                                nxt.flags[cpk_pkg::FB_INTEND] = 1'b1;
                                nxt.keyboard_byte = cpk_pkg::KB_END;
                                res.irq_raise = 1'b1;
                            end
                        end else if (ac == cfg.cancel_code) begin
                            if (keyen) begin
                                nxt.flags[cpk_pkg::FB_INTEND] = 1'b1;
                                nxt.keyboard_byte = cpk_pkg::KB_CANCEL;
                                res.irq_raise = 1'b1;
                            end
                        end else if (ac == cfg.return_code) begin
                            if (keyen) begin
                                nxt.flags[cpk_pkg::FB_INTKEY] = 1'b1;
                                nxt.keyboard_byte = cpk_pkg::KB_RETURN;
                                res.irq_raise = 1'b1;
                            end
                        end else if (keyen) begin
                            nxt.flags[cpk_pkg::FB_INTKEY] = 1'b1;
                            res.irq_raise = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.request_light = nxt.flags[cpk_pkg::FB_REQLIGHT];
        res.proceed_light = nxt.flags[cpk_pkg::FB_PROLIGHT];
    end

endmodule

/* sv/console_printer_keyboard_io_core.sv */
// Top level of the console printer/keyboard adapter: input register, step logic, result register.
//
//  channel   ports                         direction  payload
//  input     s_valid s_ready s_item        in         cpk_pkg::in_item_t
//  result    m_valid m_ready m_item        out        cpk_pkg::out_item_t
//  config    psel penable pwrite paddr     in/out     four 7-bit key codes at 0x0..0xC
//            pwdata prdata pready
//
//  One item per cycle sustained while m_ready is high; m_valid rises once an accepted item
//  has passed the input register and the single decode pass into the result register.
//  The device state (flag word, keyboard byte, printer byte) updates in the same
//  edge that loads the result register, so items retire strictly in order.
//  A stalled result holds the input register; s_ready stays high while the input
//  register is empty or drains on this edge. Reset clears state and valid bits.
module console_printer_keyboard_io_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cpk_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output cpk_pkg::out_item_t m_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cpk_pkg::key_cfg_t   cfg;
    logic                in_valid_reg;
    cpk_pkg::in_item_t   in_item_reg;
    logic                out_valid_reg;
    cpk_pkg::out_item_t  out_item_reg;
    cpk_pkg::dev_state_t state_reg;
    cpk_pkg::dev_state_t state_next;
    cpk_pkg::out_item_t  res_next;
    logic                advance;

    cpk_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpk_step u_step (
        .item (in_item_reg),
        .cur  (state_reg),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Move the held item into the result register when that slot is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Result register and device state advance together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
            state_reg     <= state_next;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_state_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("device state changed without a retiring item");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("retired item did not reach the result register");

    a_key_excludes_print: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_item_reg.key_consumed |->
            !out_item_reg.print_valid && out_item_reg.sense_data == 16'd0)
        else $error("key tick result carries print or sense data");

    a_no_ready_while_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |-> !s_ready)
        else $error("input accepted while both registers are full and stalled");
`endif

endmodule
